@@ hw/rtl/tlbc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlbc_pkg: shared types and constants of the translation cache
// Opcodes, status codes, field widths and the command and status groups
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package tlbc_pkg;

  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int ADDR_W    = 32;
  localparam int SLOT_W    = 6;
  localparam int CNT_W     = 32;
  localparam int STAMP_W   = 64;

  localparam int DEF_TLB_SLOTS  = 64;
  localparam int DEF_PAGE_SHIFT = 12;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_INVAL  = 2'd2
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_MISS   = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // latch the incoming request
    logic probe;   // tag compare, free search, load LRU candidates
    logic reduce;  // one level of the minimum-stamp reduction
    logic commit;  // update entries and counters, load the response
  } tlbc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_lru;  // valid insert with every slot in use
  } tlbc_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/tlbc_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlbc_req_if: request channel of the translation cache
// Valid/ready handshake with opcode and both addresses.
// ----------------------------------------------------------------------------
interface tlbc_req_if;
  logic                        valid;
  logic                        ready;
  logic [tlbc_pkg::OP_W-1:0]   opcode;
  logic [tlbc_pkg::ADDR_W-1:0] virt_addr;
  logic [tlbc_pkg::ADDR_W-1:0] phys_addr;

  modport source (output valid, output opcode, output virt_addr, output phys_addr,
                  input ready);
  modport sink   (input valid, input opcode, input virt_addr, input phys_addr,
                  output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tlbc_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlbc_rsp_if: response channel of the translation cache
// Valid/ready handshake with status, page base, slot and miss count.
// ----------------------------------------------------------------------------
interface tlbc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [tlbc_pkg::ST_W-1:0]   status;
  logic [tlbc_pkg::ADDR_W-1:0] page_base;
  logic [tlbc_pkg::SLOT_W-1:0] slot;
  logic [tlbc_pkg::CNT_W-1:0]  miss_total;

  modport source (output valid, output status, output page_base, output slot,
                  output miss_total, input ready);
  modport sink   (input valid, input status, input page_base, input slot,
                  input miss_total, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tlbc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlbc_ctrl: request sequencer of the translation cache
// Steps each request through probe, optional LRU reduction and commit,
// and owns the response valid flag.
// ----------------------------------------------------------------------------
module tlbc_ctrl #(
  parameter int TLB_SLOTS = tlbc_pkg::DEF_TLB_SLOTS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tlbc_pkg::tlbc_cmd_t      cmd,
  input  wire tlbc_pkg::tlbc_sts_t sts
);
  import tlbc_pkg::*;

  localparam int LVL   = $clog2(TLB_SLOTS);
  localparam int LCW   = (LVL > 1) ? $clog2(LVL) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_REDUCE,
    S_COMMIT
  } state_t;

  state_t           state_r;
  logic             out_valid_r;
  logic [LCW-1:0]   lvl_cnt_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.accept = (state_r == S_IDLE) && in_valid;
    cmd.probe  = (state_r == S_PROBE);
    cmd.reduce = (state_r == S_REDUCE);
    cmd.commit = (state_r == S_COMMIT) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lvl_cnt_r   <= '0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (sts.need_lru && (LVL > 0)) begin
            lvl_cnt_r <= LCW'(LVL - 1);
            state_r   <= S_REDUCE;
          end else begin
            state_r <= S_COMMIT;
          end
        end
        S_REDUCE: begin
          if (lvl_cnt_r == '0) begin
            state_r <= S_COMMIT;
          end else begin
            lvl_cnt_r <= lvl_cnt_r - 1'b1;
          end
        end
        S_COMMIT: begin
          if (cmd.commit) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/tlbc_dpath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlbc_dpath: entry storage and compute of the translation cache
// Tag lanes, frame memory, stamps, LRU reduction tree, counters and the
// response register.
// ----------------------------------------------------------------------------
module tlbc_dpath #(
  parameter int TLB_SLOTS  = tlbc_pkg::DEF_TLB_SLOTS,
  parameter int PAGE_SHIFT = tlbc_pkg::DEF_PAGE_SHIFT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tlbc_pkg::tlbc_cmd_t           cmd,
  output tlbc_pkg::tlbc_sts_t                sts,
  input  wire logic [tlbc_pkg::OP_W-1:0]     req_opcode,
  input  wire logic [tlbc_pkg::ADDR_W-1:0]   req_virt_addr,
  input  wire logic [tlbc_pkg::ADDR_W-1:0]   req_phys_addr,
  output logic      [tlbc_pkg::ST_W-1:0]     rsp_status,
  output logic      [tlbc_pkg::ADDR_W-1:0]   rsp_page_base,
  output logic      [tlbc_pkg::SLOT_W-1:0]   rsp_slot,
  output logic      [tlbc_pkg::CNT_W-1:0]    rsp_miss_total
);
  import tlbc_pkg::*;

  localparam int IDX_W  = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1;
  localparam int LVL    = $clog2(TLB_SLOTS);
  localparam int CAND_N = 1 << LVL;
  localparam int VPN_W  = ADDR_W - PAGE_SHIFT;

  // Latched request
  logic [OP_W-1:0]   op_r;
  logic [ADDR_W-1:0] va_r;
  logic [ADDR_W-1:0] pa_r;

  // Entry storage
  logic [TLB_SLOTS-1:0] valid_r;
  logic [VPN_W-1:0]     vpn_r   [TLB_SLOTS];
  logic [STAMP_W-1:0]   stamp_r [TLB_SLOTS];
  logic [VPN_W-1:0]     pfn_mem [TLB_SLOTS];
  logic [VPN_W-1:0]     pfn_rd_r;

  logic [STAMP_W-1:0] use_ctr_r;
  logic [CNT_W-1:0]   miss_ctr_r;

  // Probe results
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic             free_r;
  logic [IDX_W-1:0] free_idx_r;

  // LRU candidates
  logic [STAMP_W-1:0] cand_stamp_r [CAND_N];
  logic [IDX_W-1:0]   cand_idx_r   [CAND_N];
  logic [CAND_N-1:0]  cand_ok_r;

  // Response register
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_base_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [CNT_W-1:0]  out_miss_r;

  logic [VPN_W-1:0]     vpn_q;
  logic [TLB_SLOTS-1:0] match_vec;
  logic                 hit_c;
  logic [IDX_W-1:0]     hit_idx_c;
  logic                 free_c;
  logic [IDX_W-1:0]     free_idx_c;
  logic                 va_zero;
  logic                 pa_zero;

  assign vpn_q   = va_r[ADDR_W-1:PAGE_SHIFT];
  assign va_zero = (va_r == '0);
  assign pa_zero = (pa_r == '0);

  always_comb begin
    for (int i = 0; i < TLB_SLOTS; i++) begin
      match_vec[i] = valid_r[i] && (vpn_r[i] == vpn_q);
    end
  end

  // Lowest index wins: scan down so the last assignment is the lowest hit
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    free_c     = 1'b0;
    free_idx_c = '0;
    for (int i = TLB_SLOTS - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_c     = 1'b1;
        free_idx_c = IDX_W'(i);
      end
    end
  end

  assign sts.need_lru = (op_r == OP_INSERT) && !va_zero && !pa_zero && !free_c;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= req_opcode;
      va_r <= req_virt_addr;
      pa_r <= req_phys_addr;
    end
    if (cmd.probe) begin
      hit_r      <= hit_c;
      hit_idx_r  <= hit_idx_c;
      free_r     <= free_c;
      free_idx_r <= free_idx_c;
    end
  end

  // Candidate lanes: load stamps on probe, halve the field each reduce step
  for (genvar g = 0; g < CAND_N; g++) begin : g_cand
    if (g < CAND_N / 2) begin : g_red
      always_ff @(posedge clk) begin
        if (cmd.probe) begin
          cand_stamp_r[g] <= stamp_r[g];
          cand_idx_r[g]   <= IDX_W'(g);
        end else if (cmd.reduce) begin
          if (!cand_ok_r[2*g+1] ||
              (cand_ok_r[2*g] && (cand_stamp_r[2*g] <= cand_stamp_r[2*g+1]))) begin
            cand_stamp_r[g] <= cand_stamp_r[2*g];
            cand_idx_r[g]   <= cand_idx_r[2*g];
          end else begin
            cand_stamp_r[g] <= cand_stamp_r[2*g+1];
            cand_idx_r[g]   <= cand_idx_r[2*g+1];
          end
        end
      end
    end else if (g < TLB_SLOTS) begin : g_real
      always_ff @(posedge clk) begin
        if (cmd.probe) begin
          cand_stamp_r[g] <= stamp_r[g];
          cand_idx_r[g]   <= IDX_W'(g);
        end
      end
    end else begin : g_pad
      always_ff @(posedge clk) begin
        if (cmd.probe) begin
          cand_stamp_r[g] <= '0;
          cand_idx_r[g]   <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe) begin
      for (int i = 0; i < CAND_N; i++) begin
        cand_ok_r[i] <= (i < TLB_SLOTS);
      end
    end else if (cmd.reduce) begin
      for (int i = 0; i < CAND_N / 2; i++) begin
        cand_ok_r[i] <= cand_ok_r[2*i] || cand_ok_r[2*i+1];
      end
    end
  end

  // Commit decode
  status_t           st_c;
  logic [ADDR_W-1:0] base_c;
  logic [IDX_W-1:0]  slot_idx_c;
  logic              ins_we;
  logic              stamp_we;
  logic              inval_we;
  logic              use_inc;
  logic [IDX_W-1:0]  victim_c;
  logic [IDX_W-1:0]  stamp_idx_c;
  logic [CNT_W-1:0]  miss_nxt;
  logic [STAMP_W-1:0] use_nxt;

  assign victim_c = free_r ? free_idx_r : cand_idx_r[0];
  assign use_nxt  = use_ctr_r + 1'b1;

  always_comb begin
    st_c        = ST_MISS;
    base_c      = '0;
    slot_idx_c  = '0;
    ins_we      = 1'b0;
    stamp_we    = 1'b0;
    inval_we    = 1'b0;
    use_inc     = 1'b0;
    stamp_idx_c = hit_idx_r;
    miss_nxt    = miss_ctr_r;
    unique case (op_r)
      OP_LOOKUP: begin
        if (!va_zero) begin
          if (hit_r) begin
            st_c       = ST_OK;
            base_c     = {pfn_rd_r, {PAGE_SHIFT{1'b0}}};
            slot_idx_c = hit_idx_r;
            stamp_we   = 1'b1;
            use_inc    = 1'b1;
          end else if (miss_ctr_r != '1) begin
            miss_nxt = miss_ctr_r + 1'b1;
          end
        end
      end
      OP_INSERT: begin
        if (va_zero || pa_zero) begin
          st_c = ST_REJECT;
        end else begin
          st_c        = ST_OK;
          slot_idx_c  = victim_c;
          stamp_idx_c = victim_c;
          ins_we      = 1'b1;
          stamp_we    = 1'b1;
          use_inc     = 1'b1;
        end
      end
      OP_INVAL: begin
        if (va_zero) begin
          st_c = ST_REJECT;
        end else if (hit_r) begin
          st_c       = ST_OK;
          slot_idx_c = hit_idx_r;
          inval_we   = 1'b1;
        end
      end
      default: begin
        st_c = ST_MISS;
      end
    endcase
  end

  // Frame memory: one write port at commit, registered read at probe
  always_ff @(posedge clk) begin
    if (cmd.commit && ins_we) begin
      pfn_mem[victim_c] <= pa_r[ADDR_W-1:PAGE_SHIFT];
    end
    if (cmd.probe) begin
      pfn_rd_r <= pfn_mem[hit_idx_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (ins_we) begin
        vpn_r[victim_c] <= vpn_q;
      end
      if (stamp_we) begin
        stamp_r[stamp_idx_c] <= use_nxt;
      end
      out_status_r <= st_c;
      out_base_r   <= base_c;
      out_slot_r   <= SLOT_W'(slot_idx_c);
      out_miss_r   <= miss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      use_ctr_r  <= '0;
      miss_ctr_r <= '0;
    end else if (cmd.commit) begin
      if (ins_we) begin
        valid_r[victim_c] <= 1'b1;
      end else if (inval_we) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
      if (use_inc) begin
        use_ctr_r <= use_nxt;
      end
      miss_ctr_r <= miss_nxt;
    end
  end

  assign rsp_status     = out_status_r;
  assign rsp_page_base  = out_base_r;
  assign rsp_slot       = out_slot_r;
  assign rsp_miss_total = out_miss_r;

endmodule
`default_nettype wire

@@ hw/rtl/tlb_lru_translation_cache_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_lru_translation_cache_unit: fully associative TLB with LRU replacement
// Lookup, insert and invalidate of page translations, one response per
// request, with a saturating count of lookup misses.
// ----------------------------------------------------------------------------
// Usage:
//   in_req  carries opcode, virt_addr and phys_addr; a request is taken when
//           valid and ready are both high. ready is high only while the unit
//           is idle, so one request is in work at a time.
//   out_rsp carries status, page_base, slot and miss_total for each request.
// Sequence:
//   Lookup, invalidate and inserts into a free slot go from the accepting
//   edge to the response through a probe step (parallel tag compare,
//   free-slot search, frame memory read) and a commit step.
//   An insert with every slot in use adds a reduce step per level of the
//   minimum-stamp reduction, log2(TLB_SLOTS) levels (6 at 64 slots).
//   The probe/reduce/commit sequencer takes no new request until the
//   current one has been committed.
// Stall: the response register holds its request while out_rsp.ready is low;
//   the next request may be taken and probed meanwhile, and waits for commit.
// Reset: synchronous, active low; clears all valid bits, the stamp counter
//   and the miss counter. No clearing pass: the unit is ready at once.
// ----------------------------------------------------------------------------
module tlb_lru_translation_cache_unit #(
  parameter int TLB_SLOTS  = tlbc_pkg::DEF_TLB_SLOTS,
  parameter int PAGE_SHIFT = tlbc_pkg::DEF_PAGE_SHIFT
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tlbc_req_if.sink    in_req,
  tlbc_rsp_if.source  out_rsp
);
  import tlbc_pkg::*;

  tlbc_cmd_t cmd;   // sequencer commands to the datapath
  tlbc_sts_t sts;   // datapath status back to the sequencer

  // Sequencer: owns request ready and response valid
  tlbc_ctrl #(
    .TLB_SLOTS (TLB_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: entries, LRU tree, counters and the response payload
  tlbc_dpath #(
    .TLB_SLOTS  (TLB_SLOTS),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .req_opcode     (in_req.opcode),
    .req_virt_addr  (in_req.virt_addr),
    .req_phys_addr  (in_req.phys_addr),
    .rsp_status     (out_rsp.status),
    .rsp_page_base  (out_rsp.page_base),
    .rsp_slot       (out_rsp.slot),
    .rsp_miss_total (out_rsp.miss_total)
  );

endmodule
`default_nettype wire
